// ----- rtl/pqw_pkg.sv -----
`timescale 1ns / 1ps
// shared types, widths and constants for the quad winding test pipeline
// no dependencies; imported by every module of the block

package pqw_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int FRAC_BITS  = 4;
    localparam int COORD_W    = 16;
    localparam int NUM_EDGES  = 4;
    localparam int SUM_W      = 4;

    // test point: pixel scaled to the corner format plus one half
    localparam int TP_W   = PIXEL_BITS + FRAC_BITS;
    localparam int HALF   = 1 << (FRAC_BITS - 1);
    // signed width that holds any corner, test point and their differences
    localparam int DIFF_W = ((TP_W + 1 > COORD_W) ? TP_W + 1 : COORD_W) + 1;
    localparam int PROD_W = 2 * DIFF_W;

    // stream packing
    localparam int CORNER_OFS = 2 * PIXEL_BITS;
    localparam int IN_W       = CORNER_OFS + 2 * NUM_EDGES * COORD_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int SUM_OFS    = 2 * PIXEL_BITS;
    localparam int INSIDE_OFS = SUM_OFS + SUM_W;
    localparam int OUT_W      = INSIDE_OFS + 1;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [COORD_W-1:0]    coord_t;

    typedef struct packed {
        pixel_t                    col;
        pixel_t                    row;
        coord_t [NUM_EDGES-1:0]    cx;
        coord_t [NUM_EDGES-1:0]    cy;
    } pqw_item_t;

    // one edge after setup
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] tdx;
        logic signed [DIFF_W-1:0] tdy;
        logic                     live;
        logic                     vert;
        logic                     vert_left;
        logic                     up;
    } pqw_setup_edge_t;

    typedef struct packed {
        pixel_t                               col;
        pixel_t                               row;
        pqw_setup_edge_t [NUM_EDGES-1:0]      edges;
    } pqw_setup_t;

    // one edge after the cross products
    typedef struct packed {
        logic signed [PROD_W-1:0] lhs;
        logic signed [PROD_W-1:0] rhs;
        logic                     live;
        logic                     vert;
        logic                     vert_left;
        logic                     up;
    } pqw_prod_edge_t;

    typedef struct packed {
        pixel_t                              col;
        pixel_t                              row;
        pqw_prod_edge_t [NUM_EDGES-1:0]      edges;
    } pqw_prod_t;

    typedef struct packed {
        pixel_t                    col;
        pixel_t                    row;
        logic signed [SUM_W-1:0]   winding_sum;
        logic                      inside_res;
    } pqw_result_t;

    function automatic logic signed [DIFF_W-1:0] ext_coord(input coord_t c);
        return {{(DIFF_W - COORD_W){c[COORD_W-1]}}, c};
    endfunction

endpackage

// ----- rtl/point_in_quad_winding_test.sv -----
`timescale 1ns / 1ps
// Point-in-quad winding test: takes one pixel and the four corners of a quad per
// transfer and returns the winding sum of a rightward ray from the pixel centre
// plus an inside flag. Three register stages (setup, cross-product multiply,
// side decision and sum), each with its own valid bit, so a new pixel is taken
// every cycle while the output side is ready, and a result passes the setup,
// multiply and sum registers in turn before it leaves. A stall holds each stage
// in place and empty stages still take data, so the input keeps flowing until
// all three are full. The two 17 x 17 bit signed multiplies per edge fill the
// middle stage. No state survives between pixels.
// depends on pqw_pkg, pqw_setup, pqw_cross, pqw_resolve

module point_in_quad_winding_test (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pixel_col, pixel_row, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, corner4_x, corner4_y (lowest bits first)
    input  logic [pqw_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_col, out_row, winding_sum, inside_res, zero padding (lowest bits first)
    output logic [pqw_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import pqw_pkg::*;

    pqw_item_t   item;
    pqw_setup_t  setup_data;
    pqw_prod_t   prod_data;
    pqw_result_t result;
    logic        setup_valid, setup_ready;
    logic        prod_valid, prod_ready;

    // unpack the input transfer
    assign item.col = s_tdata[0 +: PIXEL_BITS];
    assign item.row = s_tdata[PIXEL_BITS +: PIXEL_BITS];
    for (genvar k = 0; k < NUM_EDGES; k++) begin : g_unpack
        assign item.cx[k] = s_tdata[CORNER_OFS + 2 * k * COORD_W +: COORD_W];
        assign item.cy[k] = s_tdata[CORNER_OFS + (2 * k + 1) * COORD_W +: COORD_W];
    end

    // stage 1: test point, deltas, span and right-of checks
    pqw_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (setup_valid),
        .out_ready (setup_ready),
        .out_data  (setup_data)
    );

    // stage 2: cross products
    pqw_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (setup_valid),
        .in_ready  (setup_ready),
        .in_data   (setup_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // stage 3: side decisions and winding sum, doubles as output register
    pqw_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    // pack the result transfer
    always_comb
    begin
        m_tdata = '0;
        m_tdata[0 +: PIXEL_BITS]          = result.col;
        m_tdata[PIXEL_BITS +: PIXEL_BITS] = result.row;
        m_tdata[SUM_OFS +: SUM_W]         = result.winding_sum;
        m_tdata[INSIDE_OFS]               = result.inside_res;
    end

    // a result waiting on the output keeps the middle stage from draining
    a_hold_middle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && prod_valid) |=> prod_valid)
        else $error("middle stage lost an item during an output stall");

    // the inside flag agrees with the sum carried alongside it
    a_inside_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.inside_res == (result.winding_sum != '0)))
        else $error("inside flag disagrees with winding sum");

    // with four quad sides the sum stays within plus or minus four
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.winding_sum >= -SUM_W'(4) && result.winding_sum <= SUM_W'(4)))
        else $error("winding sum out of range");

    // an accepted transfer is in stage 1 on the next cycle
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> setup_valid)
        else $error("accepted transfer did not enter the pipeline");

endmodule

// ----- rtl/pqw_setup.sv -----
`timescale 1ns / 1ps
// first stage: test point, edge deltas and span / position checks
// depends on pqw_pkg

module pqw_setup (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pqw_pkg::pqw_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output pqw_pkg::pqw_setup_t out_data
);
    import pqw_pkg::*;

    logic                      valid_reg;
    pqw_setup_t                data_reg;
    pqw_setup_t                data_next;
    logic signed [DIFF_W-1:0]  tx;
    logic signed [DIFF_W-1:0]  ty;

    assign tx = $signed({{(DIFF_W - TP_W){1'b0}},
                         (TP_W'(in_item.col) << FRAC_BITS) | TP_W'(HALF)});
    assign ty = $signed({{(DIFF_W - TP_W){1'b0}},
                         (TP_W'(in_item.row) << FRAC_BITS) | TP_W'(HALF)});

    assign data_next.col = in_item.col;
    assign data_next.row = in_item.row;

    for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
        localparam int N = (k == NUM_EDGES - 1) ? 0 : k + 1;
        logic signed [DIFF_W-1:0] x1, y1, x2, y2;
        logic in_span, right_of;

        assign x1 = ext_coord(in_item.cx[k]);
        assign y1 = ext_coord(in_item.cy[k]);
        assign x2 = ext_coord(in_item.cx[N]);
        assign y2 = ext_coord(in_item.cy[N]);

        // y span with both ends inclusive
        assign in_span  = ((ty >= y1) && (ty <= y2)) || ((ty >= y2) && (ty <= y1));
        assign right_of = (tx > x1) && (tx > x2);

        assign data_next.edges[k].dx        = x2 - x1;
        assign data_next.edges[k].dy        = y2 - y1;
        assign data_next.edges[k].tdx       = tx - x1;
        assign data_next.edges[k].tdy       = ty - y1;
        assign data_next.edges[k].live      = (y1 != y2) && in_span && !right_of;
        assign data_next.edges[k].vert      = (x1 == x2);
        assign data_next.edges[k].vert_left = (tx <= x1);
        assign data_next.edges[k].up        = (y2 > y1);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/pqw_cross.sv -----
`timescale 1ns / 1ps
// second stage: two cross-product multiplies per edge
// depends on pqw_pkg

module pqw_cross (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pqw_pkg::pqw_setup_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pqw_pkg::pqw_prod_t  out_data
);
    import pqw_pkg::*;

    logic      valid_reg;
    pqw_prod_t data_reg;
    pqw_prod_t data_next;

    assign data_next.col = in_data.col;
    assign data_next.row = in_data.row;

    for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
        // (tx - x1) * dy against (ty - y1) * dx
        assign data_next.edges[k].lhs       = in_data.edges[k].tdx * in_data.edges[k].dy;
        assign data_next.edges[k].rhs       = in_data.edges[k].tdy * in_data.edges[k].dx;
        assign data_next.edges[k].live      = in_data.edges[k].live;
        assign data_next.edges[k].vert      = in_data.edges[k].vert;
        assign data_next.edges[k].vert_left = in_data.edges[k].vert_left;
        assign data_next.edges[k].up        = in_data.edges[k].up;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/pqw_resolve.sv -----
`timescale 1ns / 1ps
// third stage: per-edge side decision, winding sum, output register
// depends on pqw_pkg

module pqw_resolve (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pqw_pkg::pqw_prod_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pqw_pkg::pqw_result_t out_data
);
    import pqw_pkg::*;

    logic                                  valid_reg;
    pqw_result_t                           data_reg;
    pqw_result_t                           data_next;
    logic signed [SUM_W-1:0]               cnt [NUM_EDGES];
    logic signed [SUM_W-1:0]               sum;

    for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
        logic left;
        always_comb
        begin
            if (in_data.edges[k].vert)
            begin
                left = in_data.edges[k].vert_left;
            end
            else if (in_data.edges[k].up)
            begin
                left = in_data.edges[k].lhs < in_data.edges[k].rhs;
            end
            else
            begin
                left = in_data.edges[k].lhs > in_data.edges[k].rhs;
            end
        end
        assign cnt[k] = !(in_data.edges[k].live && left) ? SUM_W'(0) :
                        in_data.edges[k].up ? SUM_W'(1) : -SUM_W'(1);
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            sum = sum + cnt[k];
        end
    end

    assign data_next.col         = in_data.col;
    assign data_next.row         = in_data.row;
    assign data_next.winding_sum = sum;
    assign data_next.inside_res  = (sum != '0);

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for point_in_quad_winding_test: directed and random pixel/quad
// transfers, scoreboard class predicting winding sum and inside flag per pixel
// depends on pqw_pkg and the point_in_quad_winding_test rtl

module testbench;

    import pqw_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int IDLE_PERCENT  = 23;
    localparam int STEADY_FIRST  = 800;   // index of the first random item sent with no idling on either side
    localparam int STEADY_LAST   = 1100;
    localparam int HOLD_AFTER    = 300;   // items sent before the long receiver hold-off
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 8;     // three register stages plus margin
    localparam int STALL_LIMIT   = 2000;

    // one pixel and its quad, corners in the same fixed point as the block
    typedef struct {
        pixel_t col;
        pixel_t row;
        coord_t x [NUM_EDGES];
        coord_t y [NUM_EDGES];
    } pixel_quad_t;

    // ------------------------------------------------------------------
    // scoreboard: predicts the winding result of each accepted pixel and
    // checks results in order against it
    // ------------------------------------------------------------------
    class winding_scoreboard;
        pqw_result_t pending_results [$];
        int errors;
        int checked;
        int inside_seen;
        int sum_lo;
        int sum_hi;

        function new();
            errors      = 0;
            checked     = 0;
            inside_seen = 0;
            sum_lo      = 0;
            sum_hi      = 0;
        endfunction

        // crossing count of one directed edge for a ray going right from (tx, ty)
        function int edge_crossing(longint tx, longint ty, longint x1, longint y1,
                                   longint x2, longint y2);
            longint dx;
            longint dy;
            longint ylo;
            longint yhi;
            longint xhi;
            bit     left;
            dx  = x2 - x1;
            dy  = y2 - y1;
            ylo = (y1 < y2) ? y1 : y2;
            yhi = (y1 < y2) ? y2 : y1;
            xhi = (x1 < x2) ? x2 : x1;
            // horizontal edges never count, span ends are inclusive
            if (dy == 0)
                return 0;
            if (ty < ylo || ty > yhi)
                return 0;
            if (tx > xhi)
                return 0;
            if (dx == 0)
                left = (tx <= x1);
            else if (dy > 0)
                left = ((tx - x1) * dy) < ((ty - y1) * dx);
            else
                left = ((tx - x1) * dy) > ((ty - y1) * dx);
            if (!left)
                return 0;
            return (dy > 0) ? 1 : -1;
        endfunction

        // accepted input transfer: work out and queue the result it must give
        function void note_pixel(logic [IN_TDATA_W-1:0] d);
            longint      tx;
            longint      ty;
            longint      cx [NUM_EDGES];
            longint      cy [NUM_EDGES];
            int          sum;
            pqw_result_t res;
            res.col = d[0 +: PIXEL_BITS];
            res.row = d[PIXEL_BITS +: PIXEL_BITS];
            tx = (longint'(res.col) << FRAC_BITS) + HALF;
            ty = (longint'(res.row) << FRAC_BITS) + HALF;
            for (int k = 0; k < NUM_EDGES; k++)
            begin
                cx[k] = longint'($signed(d[CORNER_OFS + 2*COORD_W*k +: COORD_W]));
                cy[k] = longint'($signed(d[CORNER_OFS + 2*COORD_W*k + COORD_W +: COORD_W]));
            end
            sum = 0;
            for (int k = 0; k < NUM_EDGES; k++)
                sum += edge_crossing(tx, ty, cx[k], cy[k],
                                     cx[(k + 1) % NUM_EDGES], cy[(k + 1) % NUM_EDGES]);
            res.winding_sum = sum[SUM_W-1:0];
            res.inside_res  = (sum != 0);
            if (sum < sum_lo)
                sum_lo = sum;
            if (sum > sum_hi)
                sum_hi = sum;
            pending_results.push_back(res);
        endfunction

        function void field_check(string field, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        // accepted output transfer: compare with the oldest outstanding result
        function void check_result(logic [OUT_TDATA_W-1:0] d);
            pqw_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, d);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (want.inside_res)
                inside_seen++;
            field_check("out_col", want.col, d[0 +: PIXEL_BITS]);
            field_check("out_row", want.row, d[PIXEL_BITS +: PIXEL_BITS]);
            field_check("winding_sum", $signed(want.winding_sum),
                        $signed(d[SUM_OFS +: SUM_W]));
            field_check("inside_res", want.inside_res, d[INSIDE_OFS]);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and the block
    // ------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    winding_scoreboard quad_board;
    int  sent_count;
    int  directed_count;
    int  random_count;
    bit  steady;          // both sides stay busy while set
    int  quiet_cycles;

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    point_in_quad_winding_test u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // pixel fields in the lowest bits, then x and y of each corner in turn
    function automatic logic [IN_TDATA_W-1:0] pack_quad(pixel_quad_t q);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[0 +: PIXEL_BITS]          = q.col;
        d[PIXEL_BITS +: PIXEL_BITS] = q.row;
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            d[CORNER_OFS + 2*COORD_W*k +: COORD_W]           = q.x[k];
            d[CORNER_OFS + 2*COORD_W*k + COORD_W +: COORD_W] = q.y[k];
        end
        return d;
    endfunction

    function automatic pixel_quad_t quad_of(int col, int row, int x1, int y1, int x2, int y2,
                                            int x3, int y3, int x4, int y4);
        pixel_quad_t q;
        q.col  = pixel_t'(col);
        q.row  = pixel_t'(row);
        q.x[0] = coord_t'(x1);
        q.y[0] = coord_t'(y1);
        q.x[1] = coord_t'(x2);
        q.y[1] = coord_t'(y2);
        q.x[2] = coord_t'(x3);
        q.y[2] = coord_t'(y3);
        q.x[3] = coord_t'(x4);
        q.y[3] = coord_t'(y4);
        return q;
    endfunction

    function automatic int jitter(int centre, int spread);
        return centre + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // random pixel plus a quad drawn from one of several shapes; most quads sit
    // near the pixel centre so that every crossing case is reached often
    function automatic pixel_quad_t random_quad();
        pixel_quad_t q;
        int tx;
        int ty;
        int spread;
        int shape;
        int bx;
        int by;
        int dx;
        int dy;
        int t;
        int xl;
        int xr;
        int yb;
        int yt;
        q.col = pixel_t'($urandom_range(0, 255));
        q.row = pixel_t'($urandom_range(0, 255));
        if ($urandom_range(0, 19) == 0)
            q.col = $urandom_range(0, 1) ? pixel_t'(0) : pixel_t'(255);
        if ($urandom_range(0, 19) == 0)
            q.row = $urandom_range(0, 1) ? pixel_t'(0) : pixel_t'(255);
        tx = (int'(q.col) << FRAC_BITS) + HALF;
        ty = (int'(q.row) << FRAC_BITS) + HALF;
        case ($urandom_range(0, 3))
            0: spread = 24;
            1: spread = 160;
            2: spread = 1200;
            default: spread = 6000;
        endcase
        shape = $urandom_range(0, 9);
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            q.x[k] = coord_t'(jitter(tx, spread));
            q.y[k] = coord_t'(jitter(ty, spread));
        end
        case (shape)
            5:
            begin
                // any corner value at all, sign bits included
                for (int k = 0; k < NUM_EDGES; k++)
                begin
                    q.x[k] = coord_t'($urandom);
                    q.y[k] = coord_t'($urandom);
                end
            end
            6:
            begin
                // axis-aligned box, either winding direction, sides may touch the centre
                xl = tx - int'($urandom_range(0, 40));
                xr = tx + int'($urandom_range(0, 40));
                yb = ty - int'($urandom_range(0, 40));
                yt = ty + int'($urandom_range(0, 40));
                if ($urandom_range(0, 1))
                    q = quad_of(q.col, q.row, xl, yb, xr, yb, xr, yt, xl, yt);
                else
                    q = quad_of(q.col, q.row, xl, yb, xl, yt, xr, yt, xr, yb);
            end
            7:
            begin
                // corners snapped onto the centre lines: inclusive ends and vertical ties
                for (int k = 0; k < NUM_EDGES; k++)
                begin
                    if ($urandom_range(0, 1))
                        q.x[k] = coord_t'(tx);
                    if ($urandom_range(0, 1))
                        q.y[k] = coord_t'(ty);
                end
            end
            8:
            begin
                // repeated corners
                for (int k = 1; k < NUM_EDGES; k++)
                    if ($urandom_range(0, 1))
                    begin
                        q.x[k] = q.x[k-1];
                        q.y[k] = q.y[k-1];
                    end
            end
            9:
            begin
                // all corners on one line through a point near the centre
                bx = jitter(tx, 32);
                by = jitter(ty, 32);
                dx = jitter(0, 30);
                dy = jitter(0, 30);
                for (int k = 0; k < NUM_EDGES; k++)
                begin
                    t = jitter(0, 10);
                    q.x[k] = coord_t'(bx + t * dx);
                    q.y[k] = coord_t'(by + t * dy);
                end
            end
            default:
            begin
            end
        endcase
        return q;
    endfunction

    // offer one pixel until the block takes it, sometimes after a random gap
    task automatic send_pixel(pixel_quad_t q);
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_quad(q);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
    endtask

    // ------------------------------------------------------------------
    // transfer monitor: both sides sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                quad_board.note_pixel(s_tdata);
            if (m_tvalid && m_tready)
                quad_board.check_result(m_tdata);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout at %0t ns with %0d results outstanding",
                         $time, quad_board.pending_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side: random back-pressure, one long hold-off so the pipe fills
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && sent_count >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : sender
        pixel_quad_t directed [$];
        int          drain;
        quad_board     = new();
        sent_count     = 0;
        directed_count = 0;
        random_count   = 0;
        steady         = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest pixel inside a one-pixel square, largest pixel with the square reversed
        directed.push_back(quad_of(0, 0, 0, 0, 16, 0, 16, 16, 0, 16));
        directed.push_back(quad_of(255, 255, 4080, 4080, 4080, 4096, 4096, 4096, 4096, 4080));
        // corners at the ends of the coordinate range, both windings
        directed.push_back(quad_of(128, 77, -32768, -32768, 32767, -32768,
                                   32767, 32767, -32768, 32767));
        directed.push_back(quad_of(255, 0, -32768, -32768, -32768, 32767,
                                   32767, 32767, 32767, -32768));
        directed.push_back(quad_of(0, 255, -1, -1, -1, 5000, 5000, 5000, 5000, -1));
        // all four corners the same point
        directed.push_back(quad_of(6, 6, 100, 100, 100, 100, 100, 100, 100, 100));
        // collinear corners with the centre lying on the line
        directed.push_back(quad_of(6, 6, 0, 0, 100, 100, 200, 200, 300, 300));
        // vertical edge exactly at the centre x
        directed.push_back(quad_of(10, 3, 168, 0, 168, 400, 400, 400, 400, 0));
        // centre y level with a corner, horizontal edge on that level
        directed.push_back(quad_of(3, 5, 200, 88, 200, 300, -50, 300, -50, 88));
        // centre exactly on a slanted edge
        directed.push_back(quad_of(1, 1, 0, 0, 48, 48, -100, 48, -100, 0));
        // centre right of every edge
        directed.push_back(quad_of(200, 3, 0, 0, 100, 0, 100, 100, 0, 100));
        // centre outside the y span of the whole quad
        directed.push_back(quad_of(50, 0, 0, 1000, 2000, 1000, 2000, 2000, 0, 2000));
        // self-crossing bow tie
        directed.push_back(quad_of(12, 5, 0, 0, 400, 400, 400, 0, 0, 400));
        // two quad sides meeting at the centre level, both counted
        directed.push_back(quad_of(0, 0, 100, 0, 100, 8, 100, 100, -100, 50));
        // slanted edges on both sides, upward and downward
        directed.push_back(quad_of(20, 20, 100, 0, 500, 300, 400, 600, -50, 350));
        directed.push_back(quad_of(20, 20, 100, 0, -50, 350, 400, 600, 500, 300));
        // centre just right of a slanted edge, for two different slants
        directed.push_back(quad_of(4, 4, 60, 0, 80, 200, -200, 200, -200, 0));
        directed.push_back(quad_of(4, 4, 50, 0, 90, 200, -200, 200, -200, 0));
        // every corner bit set or clear, then alternating corner bit patterns
        directed.push_back(quad_of(170, 85, -1, -1, -1, -1, 0, 0, 0, 0));
        directed.push_back(quad_of(85, 170, 21845, -21846, -21846, 21845,
                                   21845, 21845, -21846, -21846));
        foreach (directed[i])
        begin
            send_pixel(directed[i]);
            directed_count++;
        end

        // random part, with a stretch in the middle where neither side idles
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= STEADY_FIRST && i < STEADY_LAST);
            send_pixel(random_quad());
            random_count++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // drain: watchdog covers a block that never finishes
        @(posedge clk);
        while (quad_board.pending_results.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drain++;
        end

        $display("sent %0d directed and %0d random pixel quads, %0d results checked",
                 directed_count, random_count, quad_board.checked);
        $display("%0d pixels inside, winding sums seen from %0d to %0d",
                 quad_board.inside_seen, quad_board.sum_lo, quad_board.sum_hi);
        if (quad_board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
